// File: rtl/core/utf8_string_validator_core_assert.svh
// Assertion macros for the UTF-8 string validator core.
`ifndef UTF8_STRING_VALIDATOR_CORE_ASSERT_SVH
`define UTF8_STRING_VALIDATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define UTF8V_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("utf8v check failed");

// Next-cycle implication, checked outside reset.
`define UTF8V_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("utf8v check failed");

`endif

// File: rtl/core/utf8v_pkg.sv
`default_nettype none

package utf8v_pkg;

  typedef enum logic [1:0] {
    MIN_NONE = 2'd0,
    MIN_2B   = 2'd1,
    MIN_3B   = 2'd2,
    MIN_4B   = 2'd3
  } min_class_e;

  localparam int unsigned CpW = 21;

  localparam logic [7:0] AsciiMax  = 8'h7f;
  localparam logic [7:0] Lead2Mask = 8'he0;
  localparam logic [7:0] Lead2Val  = 8'hc0;
  localparam logic [7:0] Lead3Mask = 8'hf0;
  localparam logic [7:0] Lead3Val  = 8'he0;
  localparam logic [7:0] Lead4Mask = 8'hf8;
  localparam logic [7:0] Lead4Val  = 8'hf0;
  localparam logic [7:0] ContMask  = 8'hc0;
  localparam logic [7:0] ContVal   = 8'h80;

  localparam logic [CpW-1:0] Floor2B  = 21'h00080;
  localparam logic [CpW-1:0] Floor3B  = 21'h00800;
  localparam logic [CpW-1:0] Floor4B  = 21'h10000;
  localparam logic [CpW-1:0] CpMax    = 21'h10ffff;
  localparam logic [CpW-1:0] SurroLo  = 21'h0d800;
  localparam logic [CpW-1:0] SurroHi  = 21'h0dfff;

  typedef struct packed {
    logic [1:0]     bytes_pending;
    logic [CpW-1:0] cp_acc;
    min_class_e     min_class;
    logic           error_seen;
  } scan_state_t;

endpackage

`default_nettype wire

// File: rtl/core/utf8v_intf.sv
`default_nettype none

interface utf8v_byte_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] byte_value;
  logic       last;

  modport source (output valid, has_byte, byte_value, last, input ready);
  modport sink   (input valid, has_byte, byte_value, last, output ready);
endinterface

interface utf8v_res_if;
  logic valid;
  logic ready;
  logic valid_res;

  modport source (output valid, valid_res, input ready);
  modport sink   (input valid, valid_res, output ready);
endinterface

`default_nettype wire

// File: rtl/core/utf8v_step.sv
`default_nettype none

module utf8v_step (
  input  utf8v_pkg::scan_state_t cur_i,
  input  logic                   has_byte_i,
  input  logic [7:0]             byte_value_i,
  output utf8v_pkg::scan_state_t nxt_o,
  output logic                   verdict_o
);

  logic [utf8v_pkg::CpW-1:0] acc;
  logic [utf8v_pkg::CpW-1:0] floor_val;

  assign acc = {cur_i.cp_acc[utf8v_pkg::CpW-7:0], byte_value_i[5:0]};

  always_comb begin
    case (cur_i.min_class)
      utf8v_pkg::MIN_2B: floor_val = utf8v_pkg::Floor2B;
      utf8v_pkg::MIN_3B: floor_val = utf8v_pkg::Floor3B;
      default:           floor_val = utf8v_pkg::Floor4B;
    endcase
  end

  always_comb begin
    nxt_o = cur_i;
    if (has_byte_i && !cur_i.error_seen) begin
      if (cur_i.bytes_pending != 2'd0) begin
        if ((byte_value_i & utf8v_pkg::ContMask) != utf8v_pkg::ContVal) begin
          nxt_o.error_seen = 1'b1;
        end else begin
          nxt_o.cp_acc        = acc;
          nxt_o.bytes_pending = cur_i.bytes_pending - 2'd1;
          if (cur_i.bytes_pending == 2'd1) begin
            if (acc < floor_val || acc > utf8v_pkg::CpMax ||
                (acc inside {[utf8v_pkg::SurroLo:utf8v_pkg::SurroHi]})) begin
              nxt_o.error_seen = 1'b1;
            end
            nxt_o.cp_acc    = '0;
            nxt_o.min_class = utf8v_pkg::MIN_NONE;
          end
        end
      end else if (byte_value_i == 8'h00) begin
        nxt_o.error_seen = 1'b1;
      end else if (byte_value_i <= utf8v_pkg::AsciiMax) begin
        nxt_o = cur_i;
      end else if ((byte_value_i & utf8v_pkg::Lead2Mask) == utf8v_pkg::Lead2Val) begin
        nxt_o.bytes_pending = 2'd1;
        nxt_o.cp_acc        = {16'd0, byte_value_i[4:0]};
        nxt_o.min_class     = utf8v_pkg::MIN_2B;
      end else if ((byte_value_i & utf8v_pkg::Lead3Mask) == utf8v_pkg::Lead3Val) begin
        nxt_o.bytes_pending = 2'd2;
        nxt_o.cp_acc        = {17'd0, byte_value_i[3:0]};
        nxt_o.min_class     = utf8v_pkg::MIN_3B;
      end else if ((byte_value_i & utf8v_pkg::Lead4Mask) == utf8v_pkg::Lead4Val) begin
        nxt_o.bytes_pending = 2'd3;
        nxt_o.cp_acc        = {18'd0, byte_value_i[2:0]};
        nxt_o.min_class     = utf8v_pkg::MIN_4B;
      end else begin
        nxt_o.error_seen = 1'b1;
      end
    end
  end

  assign verdict_o = !nxt_o.error_seen && (nxt_o.bytes_pending == 2'd0);

endmodule

`default_nettype wire

// File: rtl/core/utf8_string_validator_core.sv
// The verdict is registered when the end-of-string beat leaves the input register.
// One byte beat per cycle; a held verdict stalls only an end-of-string beat waiting
// in the input register. The scan state updates once per beat.
// Reset (rst_ni low, asynchronous) empties both registers and clears the scan state.
`default_nettype none
`include "utf8_string_validator_core_assert.svh"

module utf8_string_validator_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  utf8v_byte_if.sink           in_i,
  utf8v_res_if.source          out_o
);

  logic       in_valid_q;
  logic       has_byte_q;
  logic [7:0] byte_value_q;
  logic       last_q;

  logic       out_valid_q, out_valid_d;
  logic       out_res_q, out_res_d;

  utf8v_pkg::scan_state_t state_q, state_d, step_nxt;
  logic                   step_verdict;
  logic                   consume;
  logic                   in_fire;

  utf8v_step u_step (
    .cur_i        (state_q),
    .has_byte_i   (has_byte_q),
    .byte_value_i (byte_value_q),
    .nxt_o        (step_nxt),
    .verdict_o    (step_verdict)
  );

  assign consume  = in_valid_q && (!last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || consume;
  assign in_fire  = in_i.valid && in_i.ready;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_res_d   = out_res_q;
    if (consume) begin
      if (last_q) begin
        state_d     = '0;
        out_valid_d = 1'b1;
        out_res_d   = step_verdict;
      end else begin
        state_d = step_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      has_byte_q   <= in_i.has_byte;
      byte_value_q <= in_i.byte_value;
      last_q       <= in_i.last;
    end
    out_res_q <= out_res_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.valid_res = out_res_q;

  `UTF8V_ASSERT_NOW(a_stall_on_full,
                    in_valid_q && last_q && out_valid_q && !out_o.ready, !in_i.ready)
  `UTF8V_ASSERT_NEXT(a_clear_after_end, consume && last_q, state_q == '0 && out_valid_q)
  `UTF8V_ASSERT_NOW(a_pending_has_class, state_q.bytes_pending != 2'd0,
                    state_q.min_class != utf8v_pkg::MIN_NONE)

endmodule

`default_nettype wire

// File: tb/sv/utf8_string_validator_core_tb.sv
`timescale 1ns / 100ps

module utf8_string_validator_core_tb;

  logic clk_i = 1'b0;
  logic rst_ni;

  utf8v_byte_if byte_bus ();
  utf8v_res_if  res_bus ();

  utf8_string_validator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_bus),
    .out_o  (res_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [1:0]                scan_pend;
  logic [utf8v_pkg::CpW-1:0] scan_acc;
  utf8v_pkg::min_class_e     scan_class;
  logic                      scan_err;

  logic verdict_q[$];

  int in_idle_pct;
  int res_stall_pct;
  int fail_count;
  int beat_count;
  int string_count;
  int good_count;
  int bad_count;

  task automatic clear_scan();
    scan_pend  = 2'd0;
    scan_acc   = '0;
    scan_class = utf8v_pkg::MIN_NONE;
    scan_err   = 1'b0;
  endtask

  task automatic scan_byte(input logic [7:0] b);
    logic [utf8v_pkg::CpW-1:0] cp_floor;
    if (scan_err) begin
    end else if (scan_pend != 2'd0) begin
      if ((b & utf8v_pkg::ContMask) != utf8v_pkg::ContVal) begin
        scan_err = 1'b1;
      end else begin
        scan_acc  = {scan_acc[utf8v_pkg::CpW-7:0], b[5:0]};
        scan_pend = scan_pend - 2'd1;
        if (scan_pend == 2'd0) begin
          cp_floor = (scan_class == utf8v_pkg::MIN_2B) ? utf8v_pkg::Floor2B :
                     (scan_class == utf8v_pkg::MIN_3B) ? utf8v_pkg::Floor3B :
                     utf8v_pkg::Floor4B;
          if (scan_acc < cp_floor || scan_acc > utf8v_pkg::CpMax ||
              (scan_acc >= utf8v_pkg::SurroLo && scan_acc <= utf8v_pkg::SurroHi)) begin
            scan_err = 1'b1;
          end
          scan_acc   = '0;
          scan_class = utf8v_pkg::MIN_NONE;
        end
      end
    end else if (b == 8'h00) begin
      scan_err = 1'b1;
    end else if (b <= utf8v_pkg::AsciiMax) begin
    end else if ((b & utf8v_pkg::Lead2Mask) == utf8v_pkg::Lead2Val) begin
      scan_pend  = 2'd1;
      scan_acc   = {16'd0, b[4:0]};
      scan_class = utf8v_pkg::MIN_2B;
    end else if ((b & utf8v_pkg::Lead3Mask) == utf8v_pkg::Lead3Val) begin
      scan_pend  = 2'd2;
      scan_acc   = {17'd0, b[3:0]};
      scan_class = utf8v_pkg::MIN_3B;
    end else if ((b & utf8v_pkg::Lead4Mask) == utf8v_pkg::Lead4Val) begin
      scan_pend  = 2'd3;
      scan_acc   = {18'd0, b[2:0]};
      scan_class = utf8v_pkg::MIN_4B;
    end else begin
      scan_err = 1'b1;
    end
  endtask

  task automatic send_beat(input logic hb, input logic [7:0] bv, input logic lst);
    logic verdict;
    while ($urandom_range(99) < in_idle_pct) begin
      byte_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_bus.valid      <= 1'b1;
    byte_bus.has_byte   <= hb;
    byte_bus.byte_value <= bv;
    byte_bus.last       <= lst;
    do @(posedge clk_i); while (!byte_bus.ready);
    if (hb || lst) beat_count++;
    if (hb) scan_byte(bv);
    if (lst) begin
      verdict = !scan_err && scan_pend == 2'd0;
      verdict_q.push_back(verdict);
      string_count++;
      if (verdict) good_count++;
      else bad_count++;
      clear_scan();
    end
  endtask

  // end the string on the final byte, or on a bare end marker
  task automatic send_string(input logic [7:0] seq[$], input bit end_marker);
    for (int i = 0; i < seq.size(); i++) begin
      send_beat(1'b1, seq[i], !end_marker && i == seq.size() - 1);
    end
    if (end_marker || seq.size() == 0) send_beat(1'b0, 8'($urandom_range(255)), 1'b1);
  endtask

  function automatic void push_cp(ref logic [7:0] seq[$], input logic [20:0] cp,
                                  input int len);
    case (len)
      1: seq.push_back({1'b0, cp[6:0]});
      2: begin
        seq.push_back({3'b110, cp[10:6]});
        seq.push_back({2'b10, cp[5:0]});
      end
      3: begin
        seq.push_back({4'b1110, cp[15:12]});
        seq.push_back({2'b10, cp[11:6]});
        seq.push_back({2'b10, cp[5:0]});
      end
      default: begin
        seq.push_back({5'b11110, cp[20:18]});
        seq.push_back({2'b10, cp[17:12]});
        seq.push_back({2'b10, cp[11:6]});
        seq.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic void push_flaw(ref logic [7:0] seq[$]);
    int len;
    int cut;
    logic [20:0] cp;
    len = $urandom_range(4, 2);
    case ($urandom_range(6))
      0: begin
        cp = (len == 2) ? 21'($urandom_range(8'h7f)) :
             (len == 3) ? 21'($urandom_range(12'h7ff)) : 21'($urandom_range(16'hffff));
        push_cp(seq, cp, len);
      end
      1: push_cp(seq, 21'($urandom_range(16'hdfff, 16'hd800)), 3);
      2: push_cp(seq, 21'($urandom_range(21'h1fffff, 21'h110000)), 4);
      3: seq.push_back(8'($urandom_range(255)));
      4: seq.push_back(8'h00);
      5: begin
        push_cp(seq, 21'($urandom_range(21'h10ffff, 21'h80)), len);
        cut = $urandom_range(len - 1, 1);
        repeat (cut) void'(seq.pop_back());
      end
      default: begin
        push_cp(seq, 21'($urandom_range(21'h10ffff, 21'h80)), len);
        seq[seq.size() - 1] = {$urandom_range(1) ? 2'b11 : 2'b00, 6'($urandom_range(63))};
      end
    endcase
  endfunction

  function automatic void push_char(ref logic [7:0] seq[$]);
    int kind;
    logic [20:0] cp;
    kind = $urandom_range(99);
    if (kind < 40) begin
      push_cp(seq, 21'($urandom_range(8'h7f, 1)), 1);
    end else if (kind < 60) begin
      push_cp(seq, 21'($urandom_range(12'h7ff, 8'h80)), 2);
    end else if (kind < 78) begin
      do cp = 21'($urandom_range(16'hffff, 12'h800));
      while (cp >= utf8v_pkg::SurroLo && cp <= utf8v_pkg::SurroHi);
      push_cp(seq, cp, 3);
    end else begin
      push_cp(seq, 21'($urandom_range(21'h10ffff, 21'h10000)), 4);
    end
  endfunction

  task automatic test_empty_string();
    send_beat(1'b0, 8'hff, 1'b1);
    send_beat(1'b1, utf8v_pkg::AsciiMax, 1'b1);
  endtask

  task automatic test_bad_bytes();
    send_string('{8'h00}, 1'b0);
    send_string('{8'hff}, 1'b0);
    send_string('{8'h80}, 1'b0);
    send_string('{8'hc2, 8'h41}, 1'b0);
  endtask

  task automatic test_encoding_limits();
    send_string('{8'hc2, 8'h80}, 1'b0);
    send_string('{8'hc0, 8'haf}, 1'b0);
    send_string('{8'hed, 8'ha0, 8'h80}, 1'b0);
    send_string('{8'hf4, 8'h90, 8'h80, 8'h80}, 1'b0);
    send_string('{8'hf0, 8'h90, 8'h80, 8'h80, 8'h7f}, 1'b0);
  endtask

  task automatic test_cut_off();
    send_beat(1'b1, 8'he2, 1'b0);
    send_beat(1'b0, 8'h00, 1'b0);
    send_beat(1'b1, 8'h82, 1'b0);
    send_beat(1'b0, 8'h55, 1'b1);
  endtask

  task automatic test_random_strings(input int n_beats, input int idle_pct);
    logic [7:0] seq[$];
    bit clean;
    bit end_marker;
    int stop_at;
    in_idle_pct   = idle_pct;
    res_stall_pct = idle_pct;
    stop_at = beat_count + n_beats;
    while (beat_count < stop_at) begin
      seq.delete();
      clean = $urandom_range(99) < 65;
      repeat ($urandom_range(6)) begin
        if (!clean && $urandom_range(99) < 30) push_flaw(seq);
        else push_char(seq);
      end
      end_marker = $urandom_range(99) < 25;
      for (int i = 0; i < seq.size(); i++) begin
        if ($urandom_range(99) < 5) send_beat(1'b0, 8'($urandom_range(255)), 1'b0);
        send_beat(1'b1, seq[i], !end_marker && i == seq.size() - 1);
      end
      if (end_marker || seq.size() == 0) send_beat(1'b0, 8'($urandom_range(255)), 1'b1);
    end
  endtask

  always @(posedge clk_i) begin
    res_bus.ready <= ($urandom_range(99) >= res_stall_pct);
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected verdict beat, expected none, actual %0b",
                 $time, res_bus.valid_res);
        fail_count++;
      end else begin
        if (res_bus.valid_res !== verdict_q[0]) begin
          $display("%0t: valid_res mismatch, expected %0b, actual %0b",
                   $time, verdict_q[0], res_bus.valid_res);
          fail_count++;
        end
        void'(verdict_q.pop_front());
      end
    end
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    fail_count    = 0;
    beat_count    = 0;
    string_count  = 0;
    good_count    = 0;
    bad_count     = 0;
    in_idle_pct   = 32;
    res_stall_pct = 32;
    clear_scan();
    rst_ni              = 1'b0;
    byte_bus.valid      = 1'b0;
    byte_bus.has_byte   = 1'b0;
    byte_bus.byte_value = 8'h00;
    byte_bus.last       = 1'b0;
    res_bus.ready       = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_string();
    test_bad_bytes();
    test_encoding_limits();
    test_cut_off();
    test_random_strings(400, 0);
    test_random_strings(1500, 32);

    byte_bus.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Checked %0d strings over %0d byte and end beats: %0d valid, %0d invalid.",
             string_count, beat_count, good_count, bad_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/utf8v_pkg.sv
rtl/core/utf8v_intf.sv
rtl/core/utf8v_step.sv
rtl/core/utf8_string_validator_core.sv
tb/sv/utf8_string_validator_core_tb.sv
